// File: design/word_frequency_counter_defines.svh
// Assertion macros for the word frequency counter.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef WORD_FREQUENCY_COUNTER_DEFINES_SVH
`define WORD_FREQUENCY_COUNTER_DEFINES_SVH
`ifndef SYNTHESIS
// Checks a property at every rising clock edge outside reset.
`define WFC_ASSERT(lbl, ck, rstn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define WFC_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) ante |=> cons) else $error(msg);
`else
`define WFC_ASSERT(lbl, ck, rstn, prop, msg)
`define WFC_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg)
`endif
`endif

// File: design/wfc_pkg.sv
// Shared constants, codes, types and character helpers of the word frequency counter.
// Used by wfc_tokenizer and word_frequency_counter; depends on nothing.
package wfc_pkg;

    // Sizing of the word buffer and of the word table.
    localparam int MAX_WORD_LEN = 32;
    localparam int MAX_ENTRIES  = 32;
    localparam int LEN_W        = $clog2(MAX_WORD_LEN + 2);
    localparam int BIDX_W       = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int EIDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int USED_W       = $clog2(MAX_ENTRIES + 1);
    localparam int TEXT_DEPTH   = MAX_ENTRIES * MAX_WORD_LEN;
    localparam int TADDR_W      = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int COUNT_W      = 16;
    localparam int META_W       = LEN_W + COUNT_W;

    // Tokenizer phases.
    localparam logic [1:0] PH_OUT    = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_APOS   = 2'd2;
    localparam logic [1:0] PH_SECOND = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LONG = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Input modes and result kinds.
    localparam logic MODE_TEXT = 1'b0;
    localparam logic MODE_END  = 1'b1;
    localparam logic KIND_WORD = 1'b0;
    localparam logic KIND_SUM  = 1'b1;

    localparam logic [7:0] CH_APOS = 8'h27;

    // Command from the controller to the tokenizer.
    typedef struct packed {
        logic       accept;
        logic       mode;
        logic [7:0] ch;
    } tok_cmd_t;

    // Word status reported by the tokenizer.
    typedef struct packed {
        logic             fin;
        logic [LEN_W-1:0] len;
    } tok_stat_t;

    function automatic logic is_alnum(input logic [7:0] c);
        is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
                   (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        to_lower = (c >= 8'h41 && c <= 8'h5a) ? (c + 8'd32) : c;
    endfunction

endpackage

// File: design/wfc_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on nothing.
module wfc_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and read with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/wfc_tokenizer.sv
// Tokenizer of the word frequency counter: phase, word buffer and word length.
// Depends on wfc_pkg.
module wfc_tokenizer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  wfc_pkg::tok_cmd_t         cmd,
    input  logic [wfc_pkg::BIDX_W-1:0] rd_idx,
    output wfc_pkg::tok_stat_t        stat,
    output logic [7:0]                rd_char
);

    localparam logic [wfc_pkg::LEN_W-1:0] MAXL = wfc_pkg::LEN_W'(wfc_pkg::MAX_WORD_LEN);

    logic [1:0]                 phase_reg, phase_next;
    logic [wfc_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [7:0]                 buf_reg [wfc_pkg::MAX_WORD_LEN];
    logic [wfc_pkg::LEN_W-1:0]  len_a, len_b;
    logic                       an, fin;
    logic [7:0]                 lc, da;
    logic                       wa_use, wb_use;

    // Length after one and after two appends, saturating one past the limit.
    always_comb
    begin
        an    = wfc_pkg::is_alnum(cmd.ch);
        lc    = wfc_pkg::to_lower(cmd.ch);
        len_a = (len_reg <= MAXL) ? len_reg + 1'b1 : len_reg;
        len_b = (len_a <= MAXL) ? len_a + 1'b1 : len_a;
    end

    // Phase transitions and append requests for an accepted transaction.
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        fin        = 1'b0;
        wa_use     = 1'b0;
        wb_use     = 1'b0;
        da         = lc;
        if (cmd.accept)
        begin
            if (cmd.mode == wfc_pkg::MODE_END)
            begin
                fin        = 1'b1;
                phase_next = wfc_pkg::PH_OUT;
                len_next   = '0;
            end
            else
            begin
                unique case (phase_reg)
                    wfc_pkg::PH_OUT:
                    begin
                        if (an)
                        begin
                            wa_use     = 1'b1;
                            len_next   = len_a;
                            phase_next = wfc_pkg::PH_FIRST;
                        end
                    end
                    wfc_pkg::PH_FIRST:
                    begin
                        if (an)
                        begin
                            wa_use   = 1'b1;
                            len_next = len_a;
                        end
                        else if (cmd.ch == wfc_pkg::CH_APOS)
                        begin
                            phase_next = wfc_pkg::PH_APOS;
                        end
                        else
                        begin
                            fin        = 1'b1;
                            len_next   = '0;
                            phase_next = wfc_pkg::PH_OUT;
                        end
                    end
                    wfc_pkg::PH_APOS:
                    begin
                        if (an)
                        begin
                            wa_use     = 1'b1;
                            wb_use     = 1'b1;
                            da         = wfc_pkg::CH_APOS;
                            len_next   = len_b;
                            phase_next = wfc_pkg::PH_SECOND;
                        end
                        else
                        begin
                            fin        = 1'b1;
                            len_next   = '0;
                            phase_next = wfc_pkg::PH_OUT;
                        end
                    end
                    default:
                    begin
                        if (an)
                        begin
                            wa_use   = 1'b1;
                            len_next = len_a;
                        end
                        else
                        begin
                            fin        = 1'b1;
                            len_next   = '0;
                            phase_next = wfc_pkg::PH_OUT;
                        end
                    end
                endcase
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= wfc_pkg::PH_OUT;
            len_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
        end
    end

    // Word buffer; characters past the limit are dropped.
    always_ff @(posedge clk)
    begin
        if (wa_use && len_reg < MAXL)
        begin
            buf_reg[len_reg[wfc_pkg::BIDX_W-1:0]] <= da;
        end
        if (wb_use && len_a < MAXL)
        begin
            buf_reg[len_a[wfc_pkg::BIDX_W-1:0]] <= lc;
        end
    end

    assign stat.fin = fin;
    assign stat.len = len_reg;
    assign rd_char  = buf_reg[rd_idx];

endmodule

// File: design/word_frequency_counter.sv
// Word frequency counter top level: lookup and insert sequencer around the word table.
// Depends on wfc_pkg, wfc_ram, wfc_tokenizer and word_frequency_counter_defines.svh.
//
// A text byte that does not end a word is taken while busy stays low. A byte that ends a
// nonempty word, or an end transaction that ends one, starts a table walk if no sticky
// error is set, the word fits and the table has room: a length check in the metadata RAM
// per entry and, on a length match, a compare of each character from the text RAM; then
// a count update for a hit or a write of each character for a new word, and the summary
// after an end transaction. An empty table skips the walk. Results appear
// for one cycle each with strobe high while busy is high; the receiver cannot stall them,
// and the next transaction is taken once busy falls.
`include "word_frequency_counter_defines.svh"
module word_frequency_counter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [7:0]  char_in,
    output logic        strobe,
    output logic        kind,
    output logic [4:0]  entry_index,
    output logic [15:0] word_count_value,
    output logic        is_new,
    output logic [7:0]  char_out,
    output logic [4:0]  char_position,
    output logic [1:0]  status,
    output logic [5:0]  distinct_words,
    output logic        last
);

    localparam int LEN_W   = wfc_pkg::LEN_W;
    localparam int BIDX_W  = wfc_pkg::BIDX_W;
    localparam int EIDX_W  = wfc_pkg::EIDX_W;
    localparam int USED_W  = wfc_pkg::USED_W;
    localparam int TADDR_W = wfc_pkg::TADDR_W;
    localparam int COUNT_W = wfc_pkg::COUNT_W;
    localparam int META_W  = wfc_pkg::META_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MCHK = 3'd1;
    localparam logic [2:0] S_TCHK = 3'd2;
    localparam logic [2:0] S_HIT  = 3'd3;
    localparam logic [2:0] S_INS  = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    logic [2:0]         state_reg, state_next;
    logic [EIDX_W-1:0]  e_reg, e_next;
    logic [BIDX_W-1:0]  i_reg, i_next;
    logic [LEN_W-1:0]   wlen_reg, wlen_next;
    logic [USED_W-1:0]  used_reg, used_next;
    logic [1:0]         err_reg, err_next;
    logic               endm_reg, endm_next;

    wfc_pkg::tok_cmd_t  tcmd;
    wfc_pkg::tok_stat_t tstat;
    logic [7:0]         wchar;

    logic               meta_we, meta_re;
    logic [EIDX_W-1:0]  meta_waddr, meta_raddr;
    logic [META_W-1:0]  meta_wdata, meta_rdata;
    logic               text_we, text_re;
    logic [TADDR_W-1:0] text_waddr, text_raddr;
    logic [7:0]         text_wdata, text_rdata;

    logic [LEN_W-1:0]   meta_len;
    logic [COUNT_W-1:0] meta_cnt, cnt_inc;
    logic [USED_W-1:0]  e_plus;
    logic [LEN_W-1:0]   i_plus;
    logic [31:0]        e_wide, i_wide, used_wide;

    function automatic logic [TADDR_W-1:0] taddr(input logic [EIDX_W-1:0] e,
                                                 input logic [BIDX_W-1:0] i);
        taddr = TADDR_W'(e) * TADDR_W'(wfc_pkg::MAX_WORD_LEN) + TADDR_W'(i);
    endfunction

    // Tokenizer and its word buffer.
    assign tcmd.accept = start && !busy;
    assign tcmd.mode   = mode;
    assign tcmd.ch     = char_in;

    wfc_tokenizer u_tok (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (tcmd),
        .rd_idx  (i_reg),
        .stat    (tstat),
        .rd_char (wchar)
    );

    // Entry metadata: length and count.
    wfc_ram #(.DEPTH(wfc_pkg::MAX_ENTRIES), .WIDTH(META_W)) u_meta (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    // Entry text, one row of MAX_WORD_LEN characters per entry.
    wfc_ram #(.DEPTH(wfc_pkg::TEXT_DEPTH), .WIDTH(8)) u_text (
        .clk   (clk),
        .we    (text_we),
        .waddr (text_waddr),
        .wdata (text_wdata),
        .re    (text_re),
        .raddr (text_raddr),
        .rdata (text_rdata)
    );

    // Helper values.
    always_comb
    begin
        meta_len  = meta_rdata[META_W-1:COUNT_W];
        meta_cnt  = meta_rdata[COUNT_W-1:0];
        cnt_inc   = (meta_cnt == COUNT_MAX) ? meta_cnt : meta_cnt + 1'b1;
        e_plus    = USED_W'(e_reg) + 1'b1;
        i_plus    = LEN_W'(i_reg) + 1'b1;
        e_wide    = 32'(e_reg);
        i_wide    = 32'(i_reg);
        used_wide = 32'(used_reg);
    end

    // Sequencer: word finish checks, table walk, hit update, insert, summary.
    always_comb
    begin
        state_next = state_reg;
        e_next     = e_reg;
        i_next     = i_reg;
        wlen_next  = wlen_reg;
        used_next  = used_reg;
        err_next   = err_reg;
        endm_next  = endm_reg;
        meta_we    = 1'b0;
        meta_waddr = e_reg;
        meta_wdata = {wlen_reg, COUNT_W'(1)};
        meta_re    = 1'b0;
        meta_raddr = '0;
        text_we    = 1'b0;
        text_waddr = taddr(e_reg, i_reg);
        text_wdata = wchar;
        text_re    = 1'b0;
        text_raddr = taddr(e_reg, i_reg);

        strobe           = 1'b0;
        kind             = wfc_pkg::KIND_WORD;
        entry_index      = '0;
        word_count_value = '0;
        is_new           = 1'b0;
        char_out         = '0;
        char_position    = '0;
        status           = wfc_pkg::ST_OK;
        distinct_words   = '0;
        last             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    endm_next = mode;
                    if (tstat.fin)
                    begin
                        wlen_next  = tstat.len;
                        state_next = (mode == wfc_pkg::MODE_END) ? S_SUM : S_IDLE;
                        if (tstat.len == '0 || err_reg != wfc_pkg::ST_OK)
                        begin
                            // Empty word or sticky error: nothing to look up.
                        end
                        else if (tstat.len > LEN_W'(wfc_pkg::MAX_WORD_LEN))
                        begin
                            err_next = wfc_pkg::ST_LONG;
                        end
                        else if (used_reg >= USED_W'(wfc_pkg::MAX_ENTRIES))
                        begin
                            err_next = wfc_pkg::ST_FULL;
                        end
                        else if (used_reg == '0)
                        begin
                            e_next     = '0;
                            i_next     = '0;
                            state_next = S_INS;
                        end
                        else
                        begin
                            e_next     = '0;
                            meta_re    = 1'b1;
                            meta_raddr = '0;
                            state_next = S_MCHK;
                        end
                    end
                end
            end
            S_MCHK:
            begin
                if (meta_len == wlen_reg)
                begin
                    i_next     = '0;
                    text_re    = 1'b1;
                    text_raddr = taddr(e_reg, '0);
                    state_next = S_TCHK;
                end
                else if (e_plus == used_reg)
                begin
                    e_next     = used_reg[EIDX_W-1:0];
                    i_next     = '0;
                    state_next = S_INS;
                end
                else
                begin
                    e_next     = e_plus[EIDX_W-1:0];
                    meta_re    = 1'b1;
                    meta_raddr = e_plus[EIDX_W-1:0];
                end
            end
            S_TCHK:
            begin
                if (text_rdata == wchar)
                begin
                    if (i_plus == wlen_reg)
                    begin
                        state_next = S_HIT;
                    end
                    else
                    begin
                        i_next     = i_plus[BIDX_W-1:0];
                        text_re    = 1'b1;
                        text_raddr = taddr(e_reg, i_plus[BIDX_W-1:0]);
                    end
                end
                else if (e_plus == used_reg)
                begin
                    e_next     = used_reg[EIDX_W-1:0];
                    i_next     = '0;
                    state_next = S_INS;
                end
                else
                begin
                    e_next     = e_plus[EIDX_W-1:0];
                    meta_re    = 1'b1;
                    meta_raddr = e_plus[EIDX_W-1:0];
                    state_next = S_MCHK;
                end
            end
            S_HIT:
            begin
                meta_we          = 1'b1;
                meta_wdata       = {meta_len, cnt_inc};
                strobe           = 1'b1;
                entry_index      = e_wide[4:0];
                word_count_value = cnt_inc;
                last             = (endm_reg == wfc_pkg::MODE_TEXT);
                state_next       = (endm_reg == wfc_pkg::MODE_END) ? S_SUM : S_IDLE;
            end
            S_INS:
            begin
                meta_we          = 1'b1;
                text_we          = 1'b1;
                strobe           = 1'b1;
                entry_index      = e_wide[4:0];
                word_count_value = 16'd1;
                is_new           = 1'b1;
                char_out         = wchar;
                char_position    = i_wide[4:0];
                if (i_plus == wlen_reg)
                begin
                    used_next  = used_reg + 1'b1;
                    last       = (endm_reg == wfc_pkg::MODE_TEXT);
                    state_next = (endm_reg == wfc_pkg::MODE_END) ? S_SUM : S_IDLE;
                end
                else
                begin
                    i_next = i_plus[BIDX_W-1:0];
                end
            end
            S_SUM:
            begin
                strobe         = 1'b1;
                kind           = wfc_pkg::KIND_SUM;
                status         = err_reg;
                distinct_words = (err_reg == wfc_pkg::ST_OK) ? used_wide[5:0] : 6'd0;
                last           = 1'b1;
                used_next      = '0;
                err_next       = wfc_pkg::ST_OK;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            err_reg   <= wfc_pkg::ST_OK;
            endm_reg  <= wfc_pkg::MODE_TEXT;
            e_reg     <= '0;
            i_reg     <= '0;
            wlen_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            err_reg   <= err_next;
            endm_reg  <= endm_next;
            e_reg     <= e_next;
            i_reg     <= i_next;
            wlen_reg  <= wlen_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `WFC_ASSERT(a_strobe_busy, clk, rst_n, strobe |-> busy, "result outside a busy period")
    `WFC_ASSERT_NEXT(a_last_idle, clk, rst_n, strobe && last, !busy, "busy after final result")
    `WFC_ASSERT_NEXT(a_end_busy, clk, rst_n, start && !busy && mode == wfc_pkg::MODE_END, busy, "end transaction without summary")
    `WFC_ASSERT(a_used_range, clk, rst_n, used_reg <= USED_W'(wfc_pkg::MAX_ENTRIES), "table overfilled")
    `WFC_ASSERT(a_cmp_range, clk, rst_n, (state_reg == S_TCHK) |-> (LEN_W'(i_reg) < wlen_reg), "compare past word end")

endmodule
